FILE: hdl/mfpc_pkg.sv
// Shared types and constants for the motion flow pixel compose block.
// No dependencies; every other file refers to this package by scoped names.
package mfpc_pkg;

    localparam int PIX_W        = 16;   // sample and pixel field width on the ports
    localparam int MASK_W       = 8;    // occlusion mask width
    localparam int WT_W         = 9;    // weight width, holds 0..256
    localparam int FRAC_BITS    = 8;    // weights are out of 256
    localparam int WEIGHT_ONE   = 256;
    localparam int ROUND_BIAS   = 256;
    localparam int NUM_STAGES   = 8;    // pipeline depth, last stage is the output register

    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_TIME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_MODE = 1'd1;

    localparam logic [WT_W-1:0] BLEND_TIME_RST = 9'd128;
    localparam logic            EXTRA_MODE_RST = 1'b0;

    typedef struct packed {
        logic [PIX_W-1:0]  fwd_sample;
        logic [PIX_W-1:0]  bwd_sample;
        logic [PIX_W-1:0]  cross_x_sample;
        logic [PIX_W-1:0]  cross_y_sample;
        logic [MASK_W-1:0] fwd_mask;
        logic [MASK_W-1:0] bwd_mask;
        logic              row_end;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             row_end_out;
    } t_pix_out;

    typedef struct packed {
        logic [WT_W-1:0] blend_time;  // already limited to 0..256
        logic            extra_mode;
    } t_mfpc_cfg;

endpackage

FILE: hdl/mfpc_in_if.sv
// Valid/ready channel carrying one input pixel item.
// Depends on mfpc_pkg for the payload type.
interface mfpc_in_if;
    logic               valid;
    logic               ready;
    mfpc_pkg::t_pix_in  item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

FILE: hdl/mfpc_out_if.sv
// Valid/ready channel carrying one composed output pixel.
// Depends on mfpc_pkg for the payload type.
interface mfpc_out_if;
    logic               valid;
    logic               ready;
    mfpc_pkg::t_pix_out item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

FILE: hdl/mfpc_core.sv
// Eight-stage arithmetic datapath of the pixel compose block.
// Depends on mfpc_pkg; stage load enables come from the top level.
module mfpc_core #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic [mfpc_pkg::NUM_STAGES-1:0]    i_en,
    input  mfpc_pkg::t_mfpc_cfg                i_cfg,
    input  mfpc_pkg::t_pix_in                  i_item,
    output mfpc_pkg::t_pix_out                 o_item
);
    localparam int SW = SAMPLE_BITS;
    localparam int PW = SW + 8;     // sample times weight
    localparam int QW = SW + 16;    // mask times weighted sum
    localparam int HW = SW + 9;     // rounded QW
    localparam int UW = SW + 1;     // partial pixel, 1..2^SW
    localparam int WW = UW + mfpc_pkg::WT_W;
    localparam int FB = mfpc_pkg::FRAC_BITS;
    localparam int MW = mfpc_pkg::MASK_W;
    localparam int TW = mfpc_pkg::WT_W;

    // stage 1: clamp and complement weights
    logic [SW-1:0] w_a, w_c, w_x, w_y, w_lo, w_hi, w_ck, w_ce;
    logic [SW-1:0] r1_a, r1_c, r1_xs, r1_ys;
    logic [MW-1:0] r1_fm, r1_bm;
    logic [TW-1:0] r1_fc, r1_bc;
    logic          r1_row;

    assign w_a  = i_item.fwd_sample[SW-1:0];
    assign w_c  = i_item.bwd_sample[SW-1:0];
    assign w_x  = i_item.cross_x_sample[SW-1:0];
    assign w_y  = i_item.cross_y_sample[SW-1:0];
    assign w_lo = (w_c < w_a) ? w_c : w_a;
    assign w_hi = (w_a < w_c) ? w_c : w_a;
    assign w_ck = (w_y > w_hi) ? w_hi : ((w_y < w_lo) ? w_lo : w_y);
    assign w_ce = (w_x > w_hi) ? w_hi : ((w_x < w_lo) ? w_lo : w_x);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_a   <= w_a;
            r1_c   <= w_c;
            // cross samples: clamped in extra mode, raw in nested mode
            r1_xs  <= i_cfg.extra_mode ? w_ce : w_x;
            r1_ys  <= i_cfg.extra_mode ? w_ck : w_y;
            r1_fm  <= i_item.fwd_mask;
            r1_bm  <= i_item.bwd_mask;
            r1_fc  <= TW'(mfpc_pkg::WEIGHT_ONE) - {1'b0, i_item.fwd_mask};
            r1_bc  <= TW'(mfpc_pkg::WEIGHT_ONE) - {1'b0, i_item.bwd_mask};
            r1_row <= i_item.row_end;
        end
    end

    // stage 2: four sample-by-weight products
    logic [PW-1:0] r2_af, r2_cb, r2_bx, r2_fy;
    logic [MW-1:0] r2_fm, r2_bm;
    logic          r2_row;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_af  <= PW'(r1_a) * PW'(r1_fc);
            r2_cb  <= PW'(r1_c) * PW'(r1_bc);
            r2_bx  <= PW'(r1_bm) * PW'(r1_xs);
            r2_fy  <= PW'(r1_fm) * PW'(r1_ys);
            r2_fm  <= r1_fm;
            r2_bm  <= r1_bm;
            r2_row <= r1_row;
        end
    end

    // stage 3: weighted sums
    logic [PW-1:0] r3_sa, r3_sb, r3_af, r3_cb;
    logic [MW-1:0] r3_fm, r3_bm;
    logic          r3_row;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_sa  <= r2_cb + r2_bx;
            r3_sb  <= r2_af + r2_fy;
            r3_af  <= r2_af;
            r3_cb  <= r2_cb;
            r3_fm  <= r2_fm;
            r3_bm  <= r2_bm;
            r3_row <= r2_row;
        end
    end

    // stage 4: nested products, and the rounded extra-mode partials
    logic [PW:0]   w_hsa, w_hsb;
    logic [QW-1:0] r4_pu, r4_pv;
    logic [UW-1:0] r4_eu, r4_ev;
    logic [PW-1:0] r4_af, r4_cb;
    logic          r4_row;

    assign w_hsa = {1'b0, r3_sa} + (PW+1)'(mfpc_pkg::ROUND_BIAS);
    assign w_hsb = {1'b0, r3_sb} + (PW+1)'(mfpc_pkg::ROUND_BIAS);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r4_pu  <= QW'(r3_fm) * QW'(r3_sa);
            r4_pv  <= QW'(r3_bm) * QW'(r3_sb);
            r4_eu  <= w_hsb[PW:FB];
            r4_ev  <= w_hsa[PW:FB];
            r4_af  <= r3_af;
            r4_cb  <= r3_cb;
            r4_row <= r3_row;
        end
    end

    // stage 5: round the nested products
    logic [QW:0]   w_hpu, w_hpv;
    logic [HW-1:0] r5_hu, r5_hv;
    logic [UW-1:0] r5_eu, r5_ev;
    logic [PW-1:0] r5_af, r5_cb;
    logic          r5_row;

    assign w_hpu = {1'b0, r4_pu} + (QW+1)'(mfpc_pkg::ROUND_BIAS);
    assign w_hpv = {1'b0, r4_pv} + (QW+1)'(mfpc_pkg::ROUND_BIAS);

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r5_hu  <= w_hpu[QW:FB];
            r5_hv  <= w_hpv[QW:FB];
            r5_eu  <= r4_eu;
            r5_ev  <= r4_ev;
            r5_af  <= r4_af;
            r5_cb  <= r4_cb;
            r5_row <= r4_row;
        end
    end

    // stage 6: outer rounding, select partial pixels by mode
    logic [HW:0]   w_su, w_sv;
    logic [UW-1:0] r6_u, r6_v;
    logic          r6_row;

    assign w_su = (HW+1)'(r5_af) + (HW+1)'(r5_hu) + (HW+1)'(mfpc_pkg::ROUND_BIAS);
    assign w_sv = (HW+1)'(r5_cb) + (HW+1)'(r5_hv) + (HW+1)'(mfpc_pkg::ROUND_BIAS);

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r6_u   <= i_cfg.extra_mode ? r5_eu : w_su[UW+FB-1:FB];
            r6_v   <= i_cfg.extra_mode ? r5_ev : w_sv[UW+FB-1:FB];
            r6_row <= r5_row;
        end
    end

    // stage 7: temporal weighting
    logic [TW-1:0] w_tc;
    logic [WW-1:0] r7_wu, r7_wv;
    logic          r7_row;

    assign w_tc = TW'(mfpc_pkg::WEIGHT_ONE) - i_cfg.blend_time;

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r7_wu  <= WW'(r6_u) * WW'(w_tc);
            r7_wv  <= WW'(r6_v) * WW'(i_cfg.blend_time);
            r7_row <= r6_row;
        end
    end

    // stage 8: final mix into the output register
    logic [WW-1:0] w_mix;
    logic [UW-1:0] w_pix;
    logic [SW-1:0] r8_pix;
    logic          r8_row;

    assign w_mix = r7_wu + r7_wv;
    assign w_pix = w_mix[UW+FB-1:FB] - UW'(1);

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r8_pix <= w_pix[SW-1:0];
            r8_row <= r7_row;
        end
    end

    assign o_item.pixel_out   = mfpc_pkg::PIX_W'(r8_pix);
    assign o_item.row_end_out = r8_row;

endmodule

FILE: hdl/motion_flow_pixel_compose_top.sv
// Top level of the motion flow pixel compose block: config registers and pipeline control.
// Depends on mfpc_pkg, mfpc_in_if, mfpc_out_if and mfpc_core.
//
//   channel   dir  handshake     payload
//   i_pix     in   valid/ready   A, C, X, Y samples, F and B masks, row end
//   o_pix     out  valid/ready   composed pixel, row end
//   i_cfg_*   in   write enable  register index, data (blend_time, extra_mode)
//
// One pixel per clock while o_pix.ready stays high; o_pix.valid rises once the input
// transfer has passed through all eight register stages of the datapath.
// Reset is synchronous and active low; it empties the pipeline and restores config.
// Each stage holds while full and the one after it holds; bubbles close up under stall.
module motion_flow_pixel_compose_top #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    mfpc_in_if.sink                               i_pix,
    mfpc_out_if.source                            o_pix,
    input  logic                                  i_cfg_we,
    input  logic [mfpc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [mfpc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    localparam int N  = mfpc_pkg::NUM_STAGES;
    localparam int TW = mfpc_pkg::WT_W;

    logic [TW-1:0] r_blend_time;
    logic          r_extra_mode;
    logic [N-1:0]  r_vld;
    logic [N:0]    w_rdy;
    mfpc_pkg::t_mfpc_cfg w_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_time <= mfpc_pkg::BLEND_TIME_RST;
            r_extra_mode <= mfpc_pkg::EXTRA_MODE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mfpc_pkg::CFG_BLEND_TIME: r_blend_time <= i_cfg_data[TW-1:0];
                mfpc_pkg::CFG_EXTRA_MODE: r_extra_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // limit time to 256
    assign w_cfg.blend_time = (r_blend_time > TW'(mfpc_pkg::WEIGHT_ONE)) ?
                              TW'(mfpc_pkg::WEIGHT_ONE) : r_blend_time;
    assign w_cfg.extra_mode = r_extra_mode;

    // a stage loads when empty or when its content moves on
    always_comb begin
        w_rdy[N] = o_pix.ready;
        for (int k = N - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int k = 1; k < N; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_pix.ready = w_rdy[0];
    assign o_pix.valid = r_vld[N-1];

    mfpc_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk  (i_clk),
        .i_en   (w_rdy[N-1:0]),
        .i_cfg  (w_cfg),
        .i_item (i_pix.item),
        .o_item (o_pix.item)
    );

endmodule
